// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the calendar conversion RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, muted while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== rtl/core/ecal_pkg.sv =====
// Types, constants and table functions for the epoch-to-calendar converter.
// Depends on nothing; imported by epoch_seconds_to_calendar.
package ecal_pkg;

    localparam int EpochYear   = 1970;
    localparam int ZoneSeconds = 8 * 60 * 60;
    localparam int DaySeconds  = 24 * 60 * 60;
    localparam int HourSeconds = 60 * 60;
    localparam int MinSeconds  = 60;

    localparam int InWidth    = 31;
    localparam int AccWidth   = 32;
    localparam int DayQWidth  = 15;
    localparam int HourWidth  = 5;
    localparam int MinWidth   = 6;
    localparam int YearWidth  = 11;
    localparam int MonthWidth = 4;
    localparam int DomWidth   = 5;
    localparam int CntWidth   = 4;

    // Centuries and 400-year cycle position of the epoch year.
    localparam int Cent100Start = EpochYear % 100;
    localparam int Cent400Start = EpochYear % 400;

    localparam logic [MonthWidth-1:0] MonthLast = MonthWidth'(11);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAY,
        S_HOUR,
        S_MIN,
        S_YEAR,
        S_MONTH,
        S_DONE
    } ecal_state_t;

    // Length of a month, zero-based month index.
    function automatic logic [DomWidth-1:0] month_len(input logic [MonthWidth-1:0] m,
                                                      input logic leap);
        logic [DomWidth-1:0] len;
        begin
            unique case (m) inside
                4'd1:                    len = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
                default:                 len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// ===== rtl/core/epoch_seconds_to_calendar.sv =====
// Epoch-seconds to UTC+8 calendar converter, top level.
// Depends on ecal_pkg and assert_macros.svh.
//
// Usage:
//   The input channel carries elapsed_seconds (seconds since 1970-01-01
//   00:00 UTC). A transfer happens on a rising edge with in_valid high and
//   in_stall low. The block holds in_stall high from that transfer until the
//   result has been written to its output register, so one conversion runs
//   at a time.
//   Each conversion runs on one shared 33-bit subtract/compare unit:
//   15 steps of restoring division by the day length, 5 for hours, 6 for
//   minutes, one step per year compared from 1970 (up to 69) and one per
//   month compared (up to 12), plus one step to post the result.
//   How long a conversion runs is set by the year and month walks; a new
//   input is taken only once the previous result has been posted.
//   The output register holds year/month/day/hour/minute/second with
//   out_valid. While out_stall is high the result holds; a finished
//   conversion waits in its last step until the output register frees.
//   Reset clears the sequencer and out_valid; the block is ready at once.

`include "assert_macros.svh"

module epoch_seconds_to_calendar
    import ecal_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [InWidth-1:0]    elapsed_seconds,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [YearWidth-1:0]  year_out,
    output logic [MonthWidth-1:0] month_out,
    output logic [DomWidth-1:0]   day_out,
    output logic [HourWidth-1:0]  hour_out,
    output logic [MinWidth-1:0]   minute_out,
    output logic [MinWidth-1:0]   second_out
);

    ecal_state_t state_reg, state_next;

    // Shared working value: total seconds, then remainders, then day count.
    logic [AccWidth-1:0]   acc_reg, acc_next;
    logic [CntWidth-1:0]   cnt_reg, cnt_next;
    logic [DayQWidth-1:0]  days_reg, days_next;
    logic [HourWidth-1:0]  hour_reg, hour_next;
    logic [MinWidth-1:0]   minute_reg, minute_next;
    logic [MinWidth-1:0]   second_reg, second_next;
    logic [YearWidth-1:0]  year_reg, year_next;
    logic [6:0]            c100_reg, c100_next;
    logic [8:0]            c400_reg, c400_next;
    logic [MonthWidth-1:0] month_reg, month_next;

    logic                  out_valid_reg, out_valid_next;
    logic [YearWidth-1:0]  year_out_reg;
    logic [MonthWidth-1:0] month_out_reg;
    logic [DomWidth-1:0]   day_out_reg;
    logic [HourWidth-1:0]  hour_out_reg;
    logic [MinWidth-1:0]   minute_out_reg;
    logic [MinWidth-1:0]   second_out_reg;

    logic                  in_xfer;
    logic                  out_free;
    logic                  load_out;
    logic                  leap;
    logic [8:0]            ylen;
    logic [AccWidth-1:0]   sub_op;
    logic [AccWidth:0]     diff;
    logic                  take;

    assign in_xfer  = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == S_DONE) && out_free;

    // Gregorian leap rule from the running year residues.
    assign leap = ((year_reg[1:0] == 2'd0) && (c100_reg != 7'd0)) || (c400_reg == 9'd0);
    assign ylen = leap ? 9'd366 : 9'd365;

    // Shared subtract/compare unit: operand picked by the current step.
    always_comb
    begin
        unique case (state_reg)
            S_DAY:   sub_op = AccWidth'(DaySeconds) << cnt_reg;
            S_HOUR:  sub_op = AccWidth'(HourSeconds) << cnt_reg;
            S_MIN:   sub_op = AccWidth'(MinSeconds) << cnt_reg;
            S_YEAR:  sub_op = AccWidth'(ylen);
            S_MONTH: sub_op = AccWidth'(month_len(month_reg, leap));
            default: sub_op = '0;
        endcase
    end

    assign diff = {1'b0, acc_reg} - {1'b0, sub_op};
    assign take = !diff[AccWidth];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DAY;
            end
            S_DAY:
            begin
                if (cnt_reg == '0)
                    state_next = S_HOUR;
            end
            S_HOUR:
            begin
                if (cnt_reg == '0)
                    state_next = S_MIN;
            end
            S_MIN:
            begin
                if (cnt_reg == '0)
                    state_next = S_YEAR;
            end
            S_YEAR:
            begin
                if (!take)
                    state_next = S_MONTH;
            end
            S_MONTH:
            begin
                if (!take || month_reg == MonthLast)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath updates for each step.
    always_comb
    begin
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        days_next   = days_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        year_next   = year_reg;
        c100_next   = c100_reg;
        c400_next   = c400_reg;
        month_next  = month_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                // Shift into UTC+8 and start the day-count division.
                acc_next    = AccWidth'({1'b0, elapsed_seconds}) + AccWidth'(ZoneSeconds);
                cnt_next    = CntWidth'(DayQWidth - 1);
                days_next   = '0;
                hour_next   = '0;
                minute_next = '0;
            end
            S_DAY:
            begin
                if (take)
                begin
                    acc_next  = diff[AccWidth-1:0];
                    days_next = days_reg | (DayQWidth'(1) << cnt_reg);
                end
                cnt_next = (cnt_reg == '0) ? CntWidth'(HourWidth - 1) : cnt_reg - 1'b1;
            end
            S_HOUR:
            begin
                if (take)
                begin
                    acc_next  = diff[AccWidth-1:0];
                    hour_next = hour_reg | (HourWidth'(1) << cnt_reg);
                end
                cnt_next = (cnt_reg == '0) ? CntWidth'(MinWidth - 1) : cnt_reg - 1'b1;
            end
            S_MIN:
            begin
                if (take)
                begin
                    acc_next    = diff[AccWidth-1:0];
                    minute_next = minute_reg | (MinWidth'(1) << cnt_reg);
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // Remainder is the second; switch to the day count.
                    second_next = take ? diff[MinWidth-1:0] : acc_reg[MinWidth-1:0];
                    acc_next    = AccWidth'(days_reg);
                    cnt_next    = '0;
                    year_next   = YearWidth'(EpochYear);
                    c100_next   = 7'(Cent100Start);
                    c400_next   = 9'(Cent400Start);
                end
            end
            S_YEAR:
            begin
                if (take)
                begin
                    acc_next  = diff[AccWidth-1:0];
                    year_next = year_reg + 1'b1;
                    c100_next = (c100_reg == 7'd99)  ? 7'd0 : c100_reg + 1'b1;
                    c400_next = (c400_reg == 9'd399) ? 9'd0 : c400_reg + 1'b1;
                end
                else
                begin
                    month_next = '0;
                end
            end
            S_MONTH:
            begin
                if (take && month_reg != MonthLast)
                begin
                    acc_next   = diff[AccWidth-1:0];
                    month_next = month_reg + 1'b1;
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output register: load on a finished conversion, drop after a transfer.
    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        days_reg   <= days_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        year_reg   <= year_next;
        c100_reg   <= c100_next;
        c400_reg   <= c400_next;
        month_reg  <= month_next;
        if (load_out)
        begin
            year_out_reg   <= year_reg;
            month_out_reg  <= month_reg + 1'b1;
            day_out_reg    <= acc_reg[DomWidth-1:0] + 1'b1;
            hour_out_reg   <= hour_reg;
            minute_out_reg <= minute_reg;
            second_out_reg <= second_reg;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign year_out   = year_out_reg;
    assign month_out  = month_out_reg;
    assign day_out    = day_out_reg;
    assign hour_out   = hour_out_reg;
    assign minute_out = minute_out_reg;
    assign second_out = second_out_reg;

    // An input transfer always starts the day division.
    `ASSERT_CLK(a_xfer_starts, clk, rst_n, in_xfer |=> (state_reg == S_DAY))
    // A new result appears only out of the posting step.
    `ASSERT_CLK(a_rise_from_done, clk, rst_n,
                $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
    // The year walk runs on a day count that fits the quotient width.
    `ASSERT_NEVER(a_year_acc_narrow, clk, rst_n,
                  (state_reg == S_YEAR) && (acc_reg[AccWidth-1:DayQWidth] != '0))
    // A 400-year boundary is also a century and a multiple of four.
    `ASSERT_CLK(a_leap_residues, clk, rst_n,
                ((state_reg == S_YEAR) && (c400_reg == 9'd0))
                    |-> ((c100_reg == 7'd0) && (year_reg[1:0] == 2'd0)))

endmodule
